### sv/acrc_pkg.sv
// ----------------------------------------------------------------------------
// acrc_pkg
// Shared widths, constants, register indexes and saturation helpers for the
// adaptive congestion rate control block.
// ----------------------------------------------------------------------------
package acrc_pkg;

	// field widths
	localparam int CBR_W   = 17;
	localparam int DELTA_W = 25;
	localparam int AIR_W   = 16;
	localparam int TOFF_W  = 10;

	// fixed point fraction widths
	localparam int FRAC_CBR   = 16;
	localparam int FRAC_DELTA = 24;

	// internal arithmetic widths
	localparam int ERR_W   = CBR_W + 1;
	localparam int STEP_W  = DELTA_W + 2;
	localparam int MUL_A_W = DELTA_W;
	localparam int MUL_B_W = CBR_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int MAG_W   = MUL_P_W - FRAC_CBR;
	localparam int DIV_N_W = AIR_W + FRAC_DELTA;
	localparam int DIV_D_W = 34;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DELTA_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CBR_TARGET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FORGET_ALPHA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_BETA     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DELTA_CEILING = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DELTA_FLOOR   = 3'd6;

	// register reset values
	localparam logic [CBR_W-1:0]          RST_CBR_TARGET    = 17'd44564;
	localparam logic [CBR_W-1:0]          RST_FORGET_ALPHA  = 17'd1049;
	localparam logic [DELTA_W-1:0]        RST_GAIN_BETA     = 25'd20133;
	localparam logic [DELTA_W-1:0]        RST_STEP_MAX      = 25'd8389;
	localparam logic signed [DELTA_W-1:0] RST_STEP_MIN      = -25'sd4194;
	localparam logic [DELTA_W-1:0]        RST_DELTA_CEILING = 25'd503316;
	localparam logic [DELTA_W-1:0]        RST_DELTA_FLOOR   = 25'd10066;

	// operation codes
	localparam logic OP_STEP   = 1'b0;
	localparam logic OP_GLOBAL = 1'b1;

	// constants
	localparam logic [CBR_W-1:0]   ONE_CBR    = 17'd65536;
	localparam logic [DELTA_W-1:0] ONE_DELTA  = 25'd16777216;
	localparam logic [DELTA_W-1:0] SEED_MIN   = 25'd16777;
	localparam logic [DIV_D_W-1:0] SEED_DIV   = 34'd100000;
	localparam logic [DIV_N_W-1:0] SEED_RND   = 40'd50000;
	localparam logic [MUL_B_W-1:0] MS_PER_S   = 17'd1000;
	localparam logic [MUL_P_W-1:0] ROUND_HALF = 42'd32768;
	localparam logic [TOFF_W-1:0]  TOFF_MIN   = 10'd25;
	localparam logic [TOFF_W-1:0]  TOFF_MAX   = 10'd1000;

	// saturate a cbr value at 1.0
	function automatic logic [CBR_W-1:0] sat_cbr(input logic [CBR_W-1:0] v);
		return (v > ONE_CBR) ? ONE_CBR : v;
	endfunction

	// saturate a delta value at 1.0
	function automatic logic [DELTA_W-1:0] sat_delta(input logic [DELTA_W-1:0] v);
		return (v > ONE_DELTA) ? ONE_DELTA : v;
	endfunction

endpackage

### sv/acrc_if.sv
// ----------------------------------------------------------------------------
// acrc_if
// Valid/ready channels of the congestion rate control block: the input word
// channel and the result word channel.
// ----------------------------------------------------------------------------
interface acrc_in_if;
	import acrc_pkg::*;

	logic                valid;
	logic                ready;
	logic                operation;
	logic                sample_valid;
	logic [CBR_W-1:0]    cbr_value;
	logic [AIR_W-1:0]    airtime_us;

	modport source(output valid, output operation, output sample_valid,
		output cbr_value, output airtime_us, input ready);
	modport sink(input valid, input operation, input sample_valid,
		input cbr_value, input airtime_us, output ready);
endinterface

interface acrc_out_if;
	import acrc_pkg::*;

	logic                valid;
	logic                ready;
	logic [DELTA_W-1:0]  duty_delta;
	logic [CBR_W-1:0]    smoothed_cbr;
	logic [TOFF_W-1:0]   gate_off_ms;
	logic                delta_clamped;

	modport source(output valid, output duty_delta, output smoothed_cbr,
		output gate_off_ms, output delta_clamped, input ready);
	modport sink(input valid, input duty_delta, input smoothed_cbr,
		input gate_off_ms, input delta_clamped, output ready);
endinterface

### sv/adaptive_congestion_rate_control.sv
// ----------------------------------------------------------------------------
// adaptive_congestion_rate_control
// Adaptive duty-cycle congestion control: smooths the channel busy ratio,
// updates the duty delta with gain and forgetting, and derives the gate-off
// time. A small sequencer drives one shared multiplier and one divider.
// A valid step runs the gain and forgetting multiplier passes, with a divider
// pass between them to seed the delta from the airtime when it is zero, and,
// unless the new delta is zero, a multiplier and a divider pass for the
// gate-off time. The next word is accepted in the cycle after the result
// loads; global updates and skipped steps are handled while idle. A finished
// result waits in the output register while the next word is accepted. Reset
// clears sequencer, controller and output valid state, loads register defaults.
// ----------------------------------------------------------------------------
module adaptive_congestion_rate_control (
	input  logic                             clk,
	input  logic                             arst_n,
	acrc_in_if.sink                          item,
	acrc_out_if.source                       result,
	input  logic                             cfg_we,
	input  logic [acrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [acrc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import acrc_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_AVG  = 3'd1;
	localparam logic [2:0] S_MUL1 = 3'd2;
	localparam logic [2:0] S_SEED = 3'd3;
	localparam logic [2:0] S_MUL2 = 3'd4;
	localparam logic [2:0] S_MUL3 = 3'd5;
	localparam logic [2:0] S_DIV2 = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;

	// configuration registers
	logic [CBR_W-1:0]          cbr_target_q;
	logic [CBR_W-1:0]          forget_alpha_q;
	logic [DELTA_W-1:0]        gain_beta_q;
	logic [DELTA_W-1:0]        step_max_q;
	logic signed [DELTA_W-1:0] step_min_q;
	logic [DELTA_W-1:0]        delta_ceiling_q;
	logic [DELTA_W-1:0]        delta_floor_q;

	// controller state
	logic [CBR_W-1:0]   local_now_q;
	logic [CBR_W-1:0]   local_prev_q;
	logic [CBR_W-1:0]   global_now_q;
	logic [CBR_W-1:0]   global_prev_q;
	logic               global_seen_q;
	logic [CBR_W-1:0]   running_q;
	logic               running_valid_q;
	logic [DELTA_W-1:0] delta_now_q;

	// per-step working registers
	logic [AIR_W-1:0]         air_q;
	logic                     err_neg_q;
	logic                     err_pos_q;
	logic signed [STEP_W-1:0] step_q;
	logic                     clamped_q;
	logic [TOFF_W-1:0]        toff_q;

	// output register
	logic               out_valid_q;
	logic [DELTA_W-1:0] out_delta_q;
	logic [CBR_W-1:0]   out_cbr_q;
	logic [TOFF_W-1:0]  out_toff_q;
	logic               out_clamped_q;

	// shared units
	logic               mul_start;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic               mul_done;
	logic [MUL_P_W-1:0] mul_prod;
	logic               div_start;
	logic [DIV_N_W-1:0] div_num;
	logic [DIV_D_W-1:0] div_den;
	logic               div_done;
	logic [DIV_N_W-1:0] div_quo;

	acrc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	acrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// saturated views of the registers
	logic [CBR_W-1:0]   tgt_sat;
	logic [CBR_W-1:0]   keep;
	logic [DELTA_W-1:0] beta_sat;
	logic [DELTA_W-1:0] smax_sat;
	logic [DELTA_W-1:0] ceil_sat;
	logic [DELTA_W-1:0] floor_sat;

	assign tgt_sat   = sat_cbr(cbr_target_q);
	assign keep      = ONE_CBR - sat_cbr(forget_alpha_q);
	assign beta_sat  = sat_delta(gain_beta_q);
	assign smax_sat  = sat_delta(step_max_q);
	assign ceil_sat  = sat_delta(delta_ceiling_q);
	assign floor_sat = sat_delta(delta_floor_q);

	// input handshake
	logic item_acc;

	assign item.ready = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;

	// pair average and running cbr
	logic [CBR_W:0]   sum_g;
	logic [CBR_W:0]   sum_l;
	logic [CBR_W:0]   sum_run;
	logic [CBR_W-1:0] avg;
	logic [CBR_W-1:0] running_next;

	assign sum_g        = {1'b0, global_now_q} + {1'b0, global_prev_q} + (CBR_W+1)'(1);
	assign sum_l        = {1'b0, local_now_q} + {1'b0, local_prev_q} + (CBR_W+1)'(1);
	assign avg          = global_seen_q ? sum_g[CBR_W:1] : sum_l[CBR_W:1];
	assign sum_run      = {1'b0, running_q} + {1'b0, avg} + (CBR_W+1)'(1);
	assign running_next = running_valid_q ? sum_run[CBR_W:1] : avg;

	// error against the target
	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W-1:0] err_abs_s;
	logic [CBR_W-1:0]        err_abs;

	assign err       = $signed({1'b0, tgt_sat}) - $signed({1'b0, running_next});
	assign err_abs_s = err[ERR_W-1] ? -err : err;
	assign err_abs   = err_abs_s[CBR_W-1:0];

	// rounded product >> 16, used for the gain factor and the forgetting term
	logic [MUL_P_W-1:0] rnd_sum;
	logic [MAG_W-1:0]   rnd_mag;

	assign rnd_sum = mul_prod + ROUND_HALF;
	assign rnd_mag = rnd_sum[MUL_P_W-1:FRAC_CBR];

	// clamped gain step
	logic signed [STEP_W-1:0] factor;
	logic signed [STEP_W-1:0] smax_s;
	logic signed [STEP_W-1:0] smin_s;
	logic signed [STEP_W-1:0] step_next;

	assign factor = err_neg_q ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
	assign smax_s = $signed({2'b00, smax_sat});
	assign smin_s = {{2{step_min_q[DELTA_W-1]}}, step_min_q};

	always_comb begin
		if (err_pos_q)
			step_next = (factor < smax_s) ? factor : smax_s;
		else
			step_next = (factor > smin_s) ? factor : smin_s;
	end

	// previous delta, seeded from airtime when zero
	logic [DELTA_W-1:0] seed;
	logic [DELTA_W-1:0] delta_base;

	assign seed       = div_quo[DELTA_W-1:0];
	assign delta_base = (state_q == S_SEED) ? ((seed > SEED_MIN) ? seed : SEED_MIN)
		: delta_now_q;

	// new delta with floor and ceiling
	logic signed [STEP_W:0]  newd;
	logic signed [STEP_W:0]  newd_cl;
	logic signed [STEP_W:0]  ceil_s;
	logic signed [STEP_W:0]  floor_s;
	logic [DELTA_W-1:0]      delta_upd;
	logic                    clamp_hit;

	assign newd    = $signed({2'b00, rnd_mag}) + $signed({step_q[STEP_W-1], step_q});
	assign ceil_s  = $signed({3'b000, ceil_sat});
	assign floor_s = $signed({3'b000, floor_sat});

	always_comb begin
		newd_cl   = newd;
		clamp_hit = 1'b0;
		if (newd_cl > ceil_s) begin
			newd_cl   = ceil_s;
			clamp_hit = 1'b1;
		end
		if (newd_cl < floor_s) begin
			newd_cl   = floor_s;
			clamp_hit = 1'b1;
		end
	end

	assign delta_upd = newd_cl[DELTA_W-1:0];

	// gate-off time clamp
	logic [TOFF_W-1:0] toff_next;

	always_comb begin
		if (div_quo < DIV_N_W'(TOFF_MIN))
			toff_next = TOFF_MIN;
		else if (div_quo > DIV_N_W'(TOFF_MAX))
			toff_next = TOFF_MAX;
		else
			toff_next = div_quo[TOFF_W-1:0];
	end

	// shared unit operand selection
	logic [DIV_N_W-1:0] air_scaled;

	assign air_scaled = {air_q, {FRAC_DELTA{1'b0}}};

	always_comb begin
		case (state_q) inside
			S_AVG: begin
				mul_a = beta_sat;
				mul_b = err_abs;
			end
			S_MUL1, S_SEED: begin
				mul_a = delta_base;
				mul_b = keep;
			end
			S_MUL2: begin
				mul_a = delta_upd;
				mul_b = MS_PER_S;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_num = (state_q == S_MUL1) ? (air_scaled + SEED_RND) : air_scaled;
	assign div_den = (state_q == S_MUL1) ? SEED_DIV : mul_prod[DIV_D_W-1:0];

	assign mul_start = (state_q == S_AVG)
		|| ((state_q == S_MUL1) && mul_done && (delta_now_q != '0))
		|| ((state_q == S_SEED) && div_done)
		|| ((state_q == S_MUL2) && mul_done && (delta_upd != '0));
	assign div_start = ((state_q == S_MUL1) && mul_done && (delta_now_q == '0))
		|| ((state_q == S_MUL3) && mul_done);

	// output register load
	logic out_load;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cbr_target_q    <= RST_CBR_TARGET;
			forget_alpha_q  <= RST_FORGET_ALPHA;
			gain_beta_q     <= RST_GAIN_BETA;
			step_max_q      <= RST_STEP_MAX;
			step_min_q      <= RST_STEP_MIN;
			delta_ceiling_q <= RST_DELTA_CEILING;
			delta_floor_q   <= RST_DELTA_FLOOR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CBR_TARGET:    cbr_target_q    <= cfg_data[CBR_W-1:0];
				REG_FORGET_ALPHA:  forget_alpha_q  <= cfg_data[CBR_W-1:0];
				REG_GAIN_BETA:     gain_beta_q     <= cfg_data;
				REG_STEP_MAX:      step_max_q      <= cfg_data;
				REG_STEP_MIN:      step_min_q      <= $signed(cfg_data);
				REG_DELTA_CEILING: delta_ceiling_q <= cfg_data;
				REG_DELTA_FLOOR:   delta_floor_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			local_now_q     <= '0;
			local_prev_q    <= '0;
			global_now_q    <= '0;
			global_prev_q   <= '0;
			global_seen_q   <= 1'b0;
			running_q       <= '0;
			running_valid_q <= 1'b0;
			delta_now_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (item.operation == OP_GLOBAL) begin
							global_prev_q <= global_seen_q ? global_now_q : '0;
							global_now_q  <= sat_cbr(item.cbr_value);
							global_seen_q <= 1'b1;
						end else if (item.sample_valid) begin
							local_prev_q <= local_now_q;
							local_now_q  <= sat_cbr(item.cbr_value);
							state_q      <= S_AVG;
						end
					end
				end
				S_AVG: begin
					running_q       <= running_next;
					running_valid_q <= 1'b1;
					state_q         <= S_MUL1;
				end
				S_MUL1: begin
					if (mul_done)
						state_q <= (delta_now_q == '0) ? S_SEED : S_MUL2;
				end
				S_SEED: begin
					if (div_done)
						state_q <= S_MUL2;
				end
				S_MUL2: begin
					if (mul_done) begin
						delta_now_q <= delta_upd;
						state_q     <= (delta_upd == '0) ? S_DONE : S_MUL3;
					end
				end
				S_MUL3: begin
					if (mul_done)
						state_q <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-step working values
	always_ff @(posedge clk) begin
		if (item_acc)
			air_q <= item.airtime_us;
		if (state_q == S_AVG) begin
			err_neg_q <= err[ERR_W-1];
			err_pos_q <= !err[ERR_W-1] && (err != '0);
		end
		if ((state_q == S_MUL1) && mul_done)
			step_q <= step_next;
		if ((state_q == S_MUL2) && mul_done) begin
			clamped_q <= clamp_hit;
			toff_q    <= TOFF_MAX;
		end
		if ((state_q == S_DIV2) && div_done)
			toff_q <= toff_next;
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_delta_q   <= delta_now_q;
			out_cbr_q     <= running_q;
			out_toff_q    <= toff_q;
			out_clamped_q <= clamped_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.duty_delta    = out_delta_q;
	assign result.smoothed_cbr  = out_cbr_q;
	assign result.gate_off_ms   = out_toff_q;
	assign result.delta_clamped = out_clamped_q;

endmodule

### sv/acrc_mul.sv
// ----------------------------------------------------------------------------
// acrc_mul
// Shift-and-add multiplier, one multiplier bit per cycle. Operands are taken
// on start; done pulses for one cycle when the product is ready.
// ----------------------------------------------------------------------------
module acrc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [acrc_pkg::MUL_A_W-1:0]  a,
	input  logic [acrc_pkg::MUL_B_W-1:0]  b,
	output logic                          done,
	output logic [acrc_pkg::MUL_P_W-1:0]  prod
);
	import acrc_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W + 1);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(MUL_B_W);

	logic [MUL_P_W-1:0] acc_q;
	logic [MUL_P_W-1:0] a_sh_q;
	logic [MUL_B_W-1:0] b_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	// control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: add the shifted multiplicand for each set multiplier bit
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			a_sh_q <= {{MUL_B_W{1'b0}}, a};
			b_q    <= b;
		end else if (busy_q) begin
			if (b_q[0])
				acc_q <= acc_q + a_sh_q;
			a_sh_q <= {a_sh_q[MUL_P_W-2:0], 1'b0};
			b_q    <= {1'b0, b_q[MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

### sv/acrc_div.sv
// ----------------------------------------------------------------------------
// acrc_div
// Restoring divider, one quotient bit per cycle. Operands are taken on start;
// done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module acrc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [acrc_pkg::DIV_N_W-1:0]  num,
	input  logic [acrc_pkg::DIV_D_W-1:0]  den,
	output logic                          done,
	output logic [acrc_pkg::DIV_N_W-1:0]  quo
);
	import acrc_pkg::*;

	localparam int CNT_W = $clog2(DIV_N_W + 1);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(DIV_N_W);

	logic [DIV_N_W-1:0] n_q;
	logic [DIV_D_W:0]   rem_q;
	logic [DIV_D_W-1:0] d_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [DIV_D_W:0]   trial;
	logic               fits;

	// one restoring step: shift in the next dividend bit and try to subtract
	assign trial = {rem_q[DIV_D_W-1:0], n_q[DIV_N_W-1]};
	assign fits  = (trial >= {1'b0, d_q});

	// control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, d_q}) : trial;
			n_q   <= {n_q[DIV_N_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

### sv/acrc_chk.sv
// ----------------------------------------------------------------------------
// acrc_chk
// Port-level checks for the congestion rate control block: results only for
// accepted steps, bounded backlog, gate-off range and a held stalled result.
// ----------------------------------------------------------------------------
module acrc_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            in_operation,
	input logic                            in_sample_valid,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [acrc_pkg::DELTA_W-1:0]    duty_delta,
	input logic [acrc_pkg::CBR_W-1:0]      smoothed_cbr,
	input logic [acrc_pkg::TOFF_W-1:0]     gate_off_ms,
	input logic                            delta_clamped
);
	import acrc_pkg::*;

	logic [1:0] pend_q;
	logic       step_in;
	logic       res_out;

	// count valid steps whose result has not been taken yet
	assign step_in = in_valid && in_ready && (in_operation == OP_STEP) && in_sample_valid;
	assign res_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (step_in && !res_out)
			pend_q <= pend_q + 2'd1;
		else if (!step_in && res_out)
			pend_q <= pend_q - 2'd1;
	end

	// a result word always belongs to an accepted step
	a_result_owned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != 2'd0))
		else $error("result word without a pending step");

	// at most one step in work and one result waiting
	a_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two steps outstanding");

	// gate-off time stays within its clamp
	a_gate_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((gate_off_ms >= TOFF_MIN) && (gate_off_ms <= TOFF_MAX)))
		else $error("gate-off time out of range");

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(duty_delta)
			&& $stable(smoothed_cbr) && $stable(gate_off_ms) && $stable(delta_clamped)))
		else $error("stalled result word changed");

endmodule

bind adaptive_congestion_rate_control acrc_chk u_acrc_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (item.valid),
	.in_ready        (item.ready),
	.in_operation    (item.operation),
	.in_sample_valid (item.sample_valid),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.duty_delta      (result.duty_delta),
	.smoothed_cbr    (result.smoothed_cbr),
	.gate_off_ms     (result.gate_off_ms),
	.delta_clamped   (result.delta_clamped)
);
